FILE: sv/bmpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bmpd_pkg;

	// Input item opcodes.
	localparam logic [1:0] OP_PAL   = 2'd0;
	localparam logic [1:0] OP_DATA  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_BPP    = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	// Supported pixel depths.
	localparam logic [5:0] BPP_1  = 6'd1;
	localparam logic [5:0] BPP_4  = 6'd4;
	localparam logic [5:0] BPP_8  = 6'd8;
	localparam logic [5:0] BPP_24 = 6'd24;

	localparam int DIM_W      = 13;
	localparam int CFG_DW     = 13;
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_ROWS   = 4096;
	localparam int WIDTH_CAP  = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
	localparam int PAL_DEPTH_DEF = 256;

	typedef struct packed {
		logic [5:0]       bpp;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} cfg_t;

	// One pixel (or error) request handed from the sequencer to the output stage.
	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [23:0] rgb;
		logic        use_pal;
		logic        last;
		logic        done;
		logic        err;
	} pix_req_t;

	typedef struct packed {
		logic        en;
		logic [7:0]  idx;
		logic [23:0] rgb;
	} pal_wr_t;

	typedef struct packed {
		logic       en;
		logic [7:0] idx;
	} pal_rd_t;

endpackage

`default_nettype wire

FILE: sv/bmpd_palette_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bmpd_palette_ram import bmpd_pkg::*; #(
	parameter int PALETTE_DEPTH = PAL_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire pal_wr_t     wr,
	input  wire pal_rd_t     rd,
	output logic [23:0]      rdata
);

	localparam int AW = $clog2(PALETTE_DEPTH);

	logic [23:0] mem [PALETTE_DEPTH];
	logic [23:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx[AW-1:0]] <= wr.rgb;
		end
	end

	// Read data holds while no read is issued, so a stalled stage keeps its colour.
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata_q <= mem[rd.idx[AW-1:0]];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: sv/bmpd_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module bmpd_seq import bmpd_pkg::*; #(
	parameter int PALETTE_DEPTH = PAL_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] opcode,
	input  wire logic [7:0] data_byte,
	input  wire logic [7:0] palette_index,
	input  wire logic [7:0] palette_red,
	input  wire logic [7:0] palette_green,
	input  wire logic [7:0] palette_blue,
	input  wire logic       can_issue,
	output logic            issue,
	output pix_req_t        req,
	output pal_wr_t         pal_wr,
	output pal_rd_t         pal_rd
);

	localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_DEPTH);

	logic             busy_q;
	logic [1:0]       op_q;
	logic [7:0]       byte_q;
	logic [7:0]       pidx_q;
	logic [23:0]      prgb_q;
	logic [2:0]       sub_q;
	logic [DIM_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;
	logic [13:0]      rbc_q;
	logic [15:0]      partial_q;
	logic [1:0]       phase_q;

	logic [DIM_W-1:0] col_d, row_d;
	logic [13:0]      rbc_d;
	logic [15:0]      partial_d;
	logic [1:0]       phase_d;
	logic [2:0]       sub_d;

	logic [DIM_W-1:0] eff_w, eff_h, col_inc;
	logic [16:0]      prod, rnd;
	logic [13:0]      stride;
	logic [14:0]      rbc_inc;
	logic             supported, is_data, err_item, active, col_ok, has_pix, more;
	logic             need_issue, step, item_end, accept, is24;
	logic             pix_bit;
	logic [3:0]       nib;
	logic [7:0]       idx8;
	logic             idx_ok;

	always_comb begin
		if (cfg.width == '0) begin
			eff_w = DIM_W'(1);
		end else if (cfg.width > DIM_W'(WIDTH_CAP)) begin
			eff_w = DIM_W'(WIDTH_CAP);
		end else begin
			eff_w = cfg.width;
		end
		if (cfg.height == '0) begin
			eff_h = DIM_W'(1);
		end else if (cfg.height > DIM_W'(MAX_ROWS)) begin
			eff_h = DIM_W'(MAX_ROWS);
		end else begin
			eff_h = cfg.height;
		end
	end

	// Row stride in bytes, rounded up to a whole number of 32-bit words.
	always_comb begin
		case (cfg.bpp)
			BPP_1:   prod = 17'(eff_w);
			BPP_4:   prod = 17'(eff_w) << 2;
			BPP_8:   prod = 17'(eff_w) << 3;
			default: prod = (17'(eff_w) << 4) + (17'(eff_w) << 3);
		endcase
		rnd    = prod + 17'd31;
		stride = {rnd[16:5], 2'b00};
	end

	assign supported = cfg.bpp inside {BPP_1, BPP_4, BPP_8, BPP_24};
	assign is24      = (cfg.bpp == BPP_24);
	assign is_data   = busy_q && (op_q == OP_DATA);
	assign err_item  = is_data && !supported;
	assign active    = is_data && supported && (row_q < eff_h);
	assign col_ok    = (col_q < eff_w);
	assign col_inc   = col_q + DIM_W'(1);
	assign has_pix   = active && col_ok && (!is24 || (phase_q >= 2'd2));
	assign more      = active && col_ok && (col_inc < eff_w) &&
		(((cfg.bpp == BPP_1) && (sub_q != 3'd7)) || ((cfg.bpp == BPP_4) && (sub_q == 3'd0)));

	assign need_issue = has_pix || err_item;
	assign issue      = need_issue && can_issue;
	assign step       = busy_q && (!need_issue || can_issue);
	assign item_end   = step && !more;
	assign in_ready   = !busy_q || item_end;
	assign accept     = in_valid && in_ready;

	// Palette index of the pixel being issued; the leftmost bits come first.
	assign pix_bit = byte_q[3'd7 - sub_q];
	assign nib     = sub_q[0] ? byte_q[3:0] : byte_q[7:4];
	always_comb begin
		case (cfg.bpp)
			BPP_1:   idx8 = {7'd0, pix_bit};
			BPP_4:   idx8 = {4'd0, nib};
			default: idx8 = byte_q;
		endcase
	end
	assign idx_ok = {1'b0, idx8} < PAL_LIMIT;

	always_comb begin
		req         = '0;
		req.err     = err_item;
		req.last    = err_item || !more;
		if (!err_item) begin
			req.x       = col_q[11:0];
			req.y       = 12'(eff_h - DIM_W'(1) - row_q);
			req.done    = (row_q == eff_h - DIM_W'(1)) && (col_q == eff_w - DIM_W'(1));
			req.use_pal = !is24 && idx_ok;
			req.rgb     = is24 ? {byte_q, partial_q} : 24'd0;
		end
	end

	assign pal_rd.en  = issue && req.use_pal;
	assign pal_rd.idx = idx8;

	assign pal_wr.en  = busy_q && (op_q == OP_PAL) && ({1'b0, pidx_q} < PAL_LIMIT);
	assign pal_wr.idx = pidx_q;
	assign pal_wr.rgb = prgb_q;

	assign rbc_inc = {1'b0, rbc_q} + 15'd1;

	always_comb begin
		col_d     = col_q;
		row_d     = row_q;
		rbc_d     = rbc_q;
		partial_d = partial_q;
		phase_d   = phase_q;
		sub_d     = sub_q;
		if (step) begin
			if (more) begin
				sub_d = sub_q + 3'd1;
				col_d = col_inc;
			end else begin
				sub_d = '0;
				if (busy_q && (op_q == OP_START)) begin
					col_d     = '0;
					row_d     = '0;
					rbc_d     = '0;
					partial_d = '0;
					phase_d   = '0;
				end else if (active) begin
					if (has_pix) begin
						col_d = col_inc;
					end
					if (is24 && col_ok) begin
						case (phase_q)
							2'd0: begin
								partial_d[7:0] = byte_q;
								phase_d        = 2'd1;
							end
							2'd1: begin
								partial_d[15:8] = byte_q;
								phase_d         = 2'd2;
							end
							default: begin
								partial_d = '0;
								phase_d   = 2'd0;
							end
						endcase
					end
					// The byte that reaches the stride closes the row, padding included.
					if (rbc_inc >= {1'b0, stride}) begin
						rbc_d     = '0;
						col_d     = '0;
						partial_d = '0;
						phase_d   = '0;
						row_d     = row_q + DIM_W'(1);
					end else begin
						rbc_d = rbc_inc[13:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			sub_q     <= '0;
			col_q     <= '0;
			row_q     <= '0;
			rbc_q     <= '0;
			partial_q <= '0;
			phase_q   <= '0;
		end else begin
			if (!busy_q || item_end) begin
				busy_q <= accept;
			end
			sub_q     <= sub_d;
			col_q     <= col_d;
			row_q     <= row_d;
			rbc_q     <= rbc_d;
			partial_q <= partial_d;
			phase_q   <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			byte_q <= data_byte;
			pidx_q <= palette_index;
			prgb_q <= {palette_red, palette_green, palette_blue};
		end
	end

	a_issue_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> can_issue) else $error("pixel issued while the output stage is full");

	a_pixel_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && !req.err) |-> ((row_q < eff_h) && (col_q < eff_w)))
		else $error("pixel issued outside the image");

endmodule

`default_nettype wire

FILE: sv/bmpd_out.sv
`timescale 1ns / 1ps
`default_nettype none

module bmpd_out import bmpd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        issue,
	input  wire pix_req_t    req,
	output logic             can_issue,
	input  wire logic [23:0] rdata,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [11:0]      pixel_x,
	output logic [11:0]      pixel_y,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic             last_of_byte,
	output logic             image_done,
	output logic             depth_error
);

	logic     valid_s1;
	pix_req_t req_s1;
	logic     out_valid_q;
	logic     s1_adv;
	logic [23:0] colour;
	logic [11:0] x_q, y_q;
	logic [23:0] rgb_q;
	logic        last_q, done_q, err_q;

	assign s1_adv    = !out_valid_q || out_ready;
	assign can_issue = !valid_s1 || s1_adv;
	assign colour    = req_s1.use_pal ? rdata : req_s1.rgb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (can_issue) begin
				valid_s1 <= issue;
			end
			if (s1_adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_issue && issue) begin
			req_s1 <= req;
		end
		if (s1_adv && valid_s1) begin
			x_q    <= req_s1.x;
			y_q    <= req_s1.y;
			rgb_q  <= colour;
			last_q <= req_s1.last;
			done_q <= req_s1.done;
			err_q  <= req_s1.err;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_x      = x_q;
	assign pixel_y      = y_q;
	assign red          = rgb_q[23:16];
	assign green        = rgb_q[15:8];
	assign blue         = rgb_q[7:0];
	assign last_of_byte = last_q;
	assign image_done   = done_q;
	assign depth_error  = err_q;

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> (valid_s1 && $stable(req_s1)))
		else $error("stage one lost its word while the output stalled");

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && err_q) |-> (last_q && !done_q && (rgb_q == 24'd0) &&
			(x_q == 12'd0) && (y_q == 12'd0)))
		else $error("error word carries pixel fields");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && done_q) |-> last_q)
		else $error("final pixel of the image not marked last of its byte");

endmodule

`default_nettype wire

FILE: sv/bmp_pixel_stream_decoder_core.sv
// Uncompressed BMP pixel decoder.
// Input channel (in_valid/in_ready) takes one word per item: a palette write,
// a pixel-data byte or a start of a new image. Output channel
// (out_valid/out_ready) gives one word per pixel: column, top-down row, RGB
// and the last_of_byte, image_done and depth_error flags.
// Software writes depth, width and height through cfg_we/cfg_index/cfg_wdata
// while the block is idle, then sends a start word and the pixel bytes.
// A pixel-data byte gives up to eight pixels at 1 bit per pixel, two at 4
// bits, one at 8 bits; at 24 bits every third byte completes a pixel. The
// sequencer issues at most one pixel per cycle, with its palette read where
// a palette is used, while the output stage has room. Bytes are registered
// in the sequencer, then pixels pass the read stage and the output register.
// When the receiver stalls, the output register and the read stage hold and
// the sequencer waits; input is taken again once the current byte is issued.
// Reset clears position and the valid flags and sets depth 24, width 1, height 1.
// Palette contents are not cleared and must be written before use.
`timescale 1ns / 1ps
`default_nettype none

module bmp_pixel_stream_decoder_core import bmpd_pkg::*; #(
	parameter int PALETTE_DEPTH = PAL_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        opcode,
	input  wire logic [7:0]        data_byte,
	input  wire logic [7:0]        palette_index,
	input  wire logic [7:0]        palette_red,
	input  wire logic [7:0]        palette_green,
	input  wire logic [7:0]        palette_blue,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [11:0]            pixel_x,
	output logic [11:0]            pixel_y,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue,
	output logic                   last_of_byte,
	output logic                   image_done,
	output logic                   depth_error
);

	cfg_t        cfg_q;
	logic        can_issue;
	logic        issue;
	pix_req_t    req;
	pal_wr_t     pal_wr;
	pal_rd_t     pal_rd;
	logic [23:0] rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bpp    <= BPP_24;
			cfg_q.width  <= DIM_W'(1);
			cfg_q.height <= DIM_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BPP:    cfg_q.bpp    <= cfg_wdata[5:0];
				REG_WIDTH:  cfg_q.width  <= cfg_wdata[DIM_W-1:0];
				REG_HEIGHT: cfg_q.height <= cfg_wdata[DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bmpd_seq #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.data_byte    (data_byte),
		.palette_index(palette_index),
		.palette_red  (palette_red),
		.palette_green(palette_green),
		.palette_blue (palette_blue),
		.can_issue    (can_issue),
		.issue        (issue),
		.req          (req),
		.pal_wr       (pal_wr),
		.pal_rd       (pal_rd)
	);

	bmpd_palette_ram #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk  (clk),
		.wr   (pal_wr),
		.rd   (pal_rd),
		.rdata(rdata)
	);

	bmpd_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.issue       (issue),
		.req         (req),
		.can_issue   (can_issue),
		.rdata       (rdata),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.last_of_byte(last_of_byte),
		.image_done  (image_done),
		.depth_error (depth_error)
	);

endmodule

`default_nettype wire
